// ===== rtl/aabb_pkg.sv =====
`timescale 1ns / 1ps

package aabb_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COEF_WIDTH  = 16;
  localparam int COEF_FRAC   = COEF_WIDTH - 4;
  localparam int NUM_AXES    = 3;
  localparam int ROW_WIDTH   = NUM_AXES * COEF_WIDTH;
  localparam int CFG_WIDTH   = ROW_WIDTH;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
  localparam int ACC_WIDTH   = PROD_WIDTH + 2;
  localparam int FLOOR_WIDTH = ACC_WIDTH - COEF_FRAC;
  localparam int DATA_WIDTH  = 2 * NUM_AXES * COORD_WIDTH;

  localparam logic [ROW_WIDTH-1:0] ROW0_RESET = ROW_WIDTH'(4096);
  localparam logic [ROW_WIDTH-1:0] ROW1_RESET = ROW_WIDTH'(268435456);
  localparam logic [ROW_WIDTH-1:0] ROW2_RESET = ROW_WIDTH'(64'd17592186044416);

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ROW0_LINEAR = 3'd0,
    REG_ROW1_LINEAR = 3'd1,
    REG_ROW2_LINEAR = 3'd2,
    REG_TRANSLATE_X = 3'd3,
    REG_TRANSLATE_Y = 3'd4,
    REG_TRANSLATE_Z = 3'd5
  } cfg_reg_t;

endpackage

// ===== rtl/aabb_affine_transform.sv =====
`timescale 1ns / 1ps

// Bounds an axis-aligned box under the configured affine map (3x3 Q4.12 matrix
// plus Q16.16 translation) and returns the new box, saturated to Q16.16.
// The slave stream carries one input box per item and the master stream one
// result box per item; both use tvalid/tready and an item moves on a clock edge
// where both are high. The configuration port takes a write on every edge with
// cfg_we high and should only be written while no item is in flight.
// The datapath is four register stages: products, min/max selection, sums,
// and floor with saturation. One item can be accepted in every cycle in
// which s_tready is high.
// Each stage holds its item until the next stage frees up, so a stalled
// receiver fills the stages one by one; s_tready drops only when all four
// stages hold items, and no item is lost or repeated.
// Reset (rst, synchronous) empties the pipeline and loads the identity map
// with zero translation.
module aabb_affine_transform (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [aabb_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [aabb_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, 32 bits each from the lowest bit up.
  input  logic [aabb_pkg::DATA_WIDTH-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y, out_hi_z, 32 bits each
  // from the lowest bit up.
  output logic [aabb_pkg::DATA_WIDTH-1:0]      m_tdata
);

  localparam int N  = aabb_pkg::NUM_AXES;
  localparam int CW = aabb_pkg::COORD_WIDTH;
  localparam int KW = aabb_pkg::COEF_WIDTH;
  localparam int PW = aabb_pkg::PROD_WIDTH;
  localparam int AW = aabb_pkg::ACC_WIDTH;
  localparam int FW = aabb_pkg::FLOOR_WIDTH;

  logic [aabb_pkg::ROW_WIDTH-1:0] row_lin [N];
  logic signed [CW-1:0]           trans [N];

  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  logic signed [PW-1:0] prod_lo [N][N];
  logic signed [PW-1:0] prod_hi [N][N];
  logic signed [PW-1:0] sel_lo [N][N];
  logic signed [PW-1:0] sel_hi [N][N];
  logic signed [AW-1:0] acc_lo [N];
  logic signed [AW-1:0] acc_hi [N];
  logic signed [CW-1:0] res_lo [N];
  logic signed [CW-1:0] res_hi [N];

  function automatic logic signed [CW-1:0] sat_floor(input logic signed [AW-1:0] acc);
    logic signed [FW-1:0] fl;
    logic signed [FW-1:0] top;
    fl  = acc[AW-1:aabb_pkg::COEF_FRAC];
    top = fl >>> (CW - 1);
    if (top == '0 || top == '1) begin
      return fl[CW-1:0];
    end else if (fl[FW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      row_lin[0] <= aabb_pkg::ROW0_RESET;
      row_lin[1] <= aabb_pkg::ROW1_RESET;
      row_lin[2] <= aabb_pkg::ROW2_RESET;
      trans[0]   <= '0;
      trans[1]   <= '0;
      trans[2]   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        aabb_pkg::REG_ROW0_LINEAR: row_lin[0] <= cfg_data;
        aabb_pkg::REG_ROW1_LINEAR: row_lin[1] <= cfg_data;
        aabb_pkg::REG_ROW2_LINEAR: row_lin[2] <= cfg_data;
        aabb_pkg::REG_TRANSLATE_X: trans[0] <= cfg_data[CW-1:0];
        aabb_pkg::REG_TRANSLATE_Y: trans[1] <= cfg_data[CW-1:0];
        aabb_pkg::REG_TRANSLATE_Z: trans[2] <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  assign adv4     = !v4 || m_tready;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;
  assign m_tvalid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && s_tvalid) begin
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          prod_lo[i][j] <= $signed(s_tdata[j*CW +: CW]) *
                           $signed(row_lin[i][j*KW +: KW]);
          prod_hi[i][j] <= $signed(s_tdata[(j+N)*CW +: CW]) *
                           $signed(row_lin[i][j*KW +: KW]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          if (prod_lo[i][j] < prod_hi[i][j]) begin
            sel_lo[i][j] <= prod_lo[i][j];
            sel_hi[i][j] <= prod_hi[i][j];
          end else begin
            sel_lo[i][j] <= prod_hi[i][j];
            sel_hi[i][j] <= prod_lo[i][j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      for (int i = 0; i < N; i++) begin
        acc_lo[i] <= (AW'(trans[i]) <<< aabb_pkg::COEF_FRAC) + AW'(sel_lo[i][0])
                     + AW'(sel_lo[i][1]) + AW'(sel_lo[i][2]);
        acc_hi[i] <= (AW'(trans[i]) <<< aabb_pkg::COEF_FRAC) + AW'(sel_hi[i][0])
                     + AW'(sel_hi[i][1]) + AW'(sel_hi[i][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && v3) begin
      for (int i = 0; i < N; i++) begin
        res_lo[i] <= sat_floor(acc_lo[i]);
        res_hi[i] <= sat_floor(acc_hi[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      m_tdata[i*CW +: CW]     = res_lo[i];
      m_tdata[(i+N)*CW +: CW] = res_hi[i];
    end
  end

`ifndef SYNTHESIS
  a_ready_follows_sink: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("s_tready low while the receiver is ready");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:0]) <= $signed(m_tdata[127:96]) &&
                  $signed(m_tdata[63:32]) <= $signed(m_tdata[159:128]) &&
                  $signed(m_tdata[95:64]) <= $signed(m_tdata[191:160])))
    else $error("result box minimum exceeds maximum");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (!s_tready) |-> (v1 && v2 && v3 && v4 && !m_tready))
    else $error("input stalled while a stage is free");
`endif

endmodule

// ===== bench/aabb_affine_transform_test.sv =====
`timescale 1ns / 1ps

module aabb_affine_transform_test;
  import aabb_pkg::*;

  localparam int NUM_REGS = 6;
  localparam int RANDOM_PHASES = 10;
  localparam int BOXES_PER_PHASE = 175;
  localparam int HOLD_CYCLES = 60;
  localparam int STALL_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNMAPPED_HI = 3'd7;
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = 32'h7fff_ffff;
  localparam logic [COORD_WIDTH-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [COEF_WIDTH-1:0] COEF_MAX = 16'h7fff;
  localparam logic [COEF_WIDTH-1:0] COEF_MIN = 16'h8000;
  localparam logic [COEF_WIDTH-1:0] COEF_ONE = 16'h1000;

  typedef logic [DATA_WIDTH-1:0] box_t;
  typedef logic [CFG_WIDTH-1:0] cfg_word_t;
  typedef cfg_word_t map_t [NUM_REGS];

  class bounds_tracker;
    logic [ROW_WIDTH-1:0] rows [NUM_AXES];
    logic [COORD_WIDTH-1:0] offsets [NUM_AXES];
    box_t expected_bounds [$];
    int mismatches;

    function new();
      rows[0] = ROW0_RESET;
      rows[1] = ROW1_RESET;
      rows[2] = ROW2_RESET;
      foreach (offsets[i]) offsets[i] = '0;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_IDX_WIDTH-1:0] index, cfg_word_t value);
      case (index)
        REG_ROW0_LINEAR: rows[0] = value[ROW_WIDTH-1:0];
        REG_ROW1_LINEAR: rows[1] = value[ROW_WIDTH-1:0];
        REG_ROW2_LINEAR: rows[2] = value[ROW_WIDTH-1:0];
        REG_TRANSLATE_X: offsets[0] = value[COORD_WIDTH-1:0];
        REG_TRANSLATE_Y: offsets[1] = value[COORD_WIDTH-1:0];
        REG_TRANSLATE_Z: offsets[2] = value[COORD_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function logic [COORD_WIDTH-1:0] clamp(longint v);
      longint top;
      top = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
      if (v > top) return COORD_MAX;
      if (v < -top - 1) return COORD_MIN;
      return v[COORD_WIDTH-1:0];
    endfunction

    function box_t predict_bounds(box_t box);
      box_t result;
      longint acc_lo, acc_hi, coef, a, b;
      for (int i = 0; i < NUM_AXES; i++) begin
        acc_lo = longint'($signed(offsets[i])) * (longint'(1) <<< COEF_FRAC);
        acc_hi = acc_lo;
        for (int j = 0; j < NUM_AXES; j++) begin
          coef = longint'($signed(rows[i][COEF_WIDTH*j +: COEF_WIDTH]));
          a = coef * longint'($signed(box[COORD_WIDTH*j +: COORD_WIDTH]));
          b = coef * longint'($signed(box[COORD_WIDTH*(j+NUM_AXES) +: COORD_WIDTH]));
          if (a < b) begin
            acc_lo += a;
            acc_hi += b;
          end else begin
            acc_lo += b;
            acc_hi += a;
          end
        end
        result[COORD_WIDTH*i +: COORD_WIDTH] = clamp(acc_lo >>> COEF_FRAC);
        result[COORD_WIDTH*(i+NUM_AXES) +: COORD_WIDTH] = clamp(acc_hi >>> COEF_FRAC);
      end
      return result;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    function void note_box(box_t box);
      expected_bounds.push_back(predict_bounds(box));
    endfunction

    function void check_box(box_t got);
      box_t want;
      string names [2*NUM_AXES];
      names = '{"out_lo_x", "out_lo_y", "out_lo_z", "out_hi_x", "out_hi_y", "out_hi_z"};
      if (expected_bounds.size() == 0) begin
        flag($sformatf("result box %h arrived with no box pending", got));
        return;
      end
      want = expected_bounds.pop_front();
      for (int k = 0; k < 2 * NUM_AXES; k++) begin
        if (got[COORD_WIDTH*k +: COORD_WIDTH] !== want[COORD_WIDTH*k +: COORD_WIDTH])
          flag($sformatf("%s expected %h, got %h", names[k],
                         want[COORD_WIDTH*k +: COORD_WIDTH], got[COORD_WIDTH*k +: COORD_WIDTH]));
      end
    endfunction

    function int pending();
      return expected_bounds.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;
  logic s_tvalid;
  logic s_tready;
  logic [DATA_WIDTH-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [DATA_WIDTH-1:0] m_tdata;

  bounds_tracker bounds = new();
  bit idling_on = 1'b1;
  bit hold_sink = 1'b0;
  int quiet_cycles = 0;

  aabb_affine_transform DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic box_t pack_box(logic [31:0] lx, ly, lz, hx, hy, hz);
    return {hz, hy, hx, lz, ly, lx};
  endfunction

  function automatic cfg_word_t pack_row(logic [15:0] m0, m1, m2);
    return {m2, m1, m0};
  endfunction

  function automatic logic [COEF_WIDTH-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return '0;
      3: return COEF_ONE;
      4: return -COEF_ONE;
      7: return COEF_WIDTH'($urandom);
      default: return COEF_WIDTH'($urandom_range(0, 16383) - 8192);
    endcase
  endfunction

  function automatic logic [COORD_WIDTH-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      8, 9: return $urandom;
      default: return COORD_WIDTH'($urandom_range(0, 1 << 23) - (1 << 22));
    endcase
  endfunction

  function automatic map_t random_map();
    map_t words;
    for (int i = 0; i < NUM_AXES; i++) begin
      words[i] = pack_row(pick_coef(), pick_coef(), pick_coef());
      words[i + NUM_AXES] = {16'($urandom), ($urandom_range(0, 3) == 0) ? $urandom : pick_coord()};
    end
    return words;
  endfunction

  function automatic box_t random_box();
    logic [COORD_WIDTH-1:0] lo [NUM_AXES];
    logic [COORD_WIDTH-1:0] hi [NUM_AXES];
    for (int j = 0; j < NUM_AXES; j++) begin
      lo[j] = pick_coord();
      if ($urandom_range(0, 9) < 7)
        hi[j] = lo[j] + COORD_WIDTH'($urandom_range(0, 1 << 20));
      else
        hi[j] = pick_coord();
    end
    return pack_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  task automatic load_map(input map_t words, input bit poke_unmapped);
    for (int k = 0; k < NUM_REGS; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_reg_t'(k);
      cfg_data <= words[k];
      @(posedge clk);
      bounds.write_register(cfg_reg_t'(k), words[k]);
    end
    if (poke_unmapped) begin
      cfg_index <= $urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI;
      cfg_data <= CFG_WIDTH'({$urandom, $urandom});
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_box(input box_t box);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= box;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bounds.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Receiver: random stalls, and one long hold-off when the sender asks for it.
  initial begin
    m_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (s_tvalid && s_tready) bounds.note_box(s_tdata);
      if (m_tvalid && m_tready) bounds.check_box(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    map_t words;
    box_t probes [5];
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_ROW0_LINEAR;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    probes[0] = '0;
    probes[1] = pack_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    probes[2] = pack_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN);
    probes[3] = pack_box(32'h0001_8000, 32'hffff_ffff, 32'h0000_0001,
                         32'h0001_8000, 32'hffff_ffff, 32'h0000_0001);
    probes[4] = pack_box(32'hffff_ffff, 32'hfffe_8001, 32'h0000_0003,
                         32'h0003_0000, 32'h0000_0007, 32'h0000_0003);

    // Directed part: the reset map first, then the extreme maps.
    for (int m = 0; m < 5; m++) begin
      case (m)
        1: words = '{pack_row(COEF_MAX, COEF_MAX, COEF_MAX), pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                     pack_row(COEF_MAX, COEF_MAX, COEF_MAX), {16'hffff, COORD_MAX},
                     {16'h0000, COORD_MAX}, {16'h5a5a, COORD_MAX}};
        2: words = '{pack_row(COEF_MIN, COEF_MIN, COEF_MIN), pack_row(COEF_MIN, COEF_MIN, COEF_MIN),
                     pack_row(COEF_MIN, COEF_MIN, COEF_MIN), {16'h0000, COORD_MIN},
                     {16'hffff, COORD_MIN}, {16'ha5a5, COORD_MIN}};
        3: words = '{'0, '0, '0, {16'h1234, 32'h0002_8000}, {16'h0000, 32'hffff_0001},
                     {16'h0000, 32'h0000_0000}};
        4: words = '{pack_row(-COEF_ONE, 16'hf801, 16'h0003),
                     pack_row(16'h07ff, COEF_ONE, 16'hfffd),
                     pack_row(16'h8001, 16'h0001, -COEF_ONE),
                     {16'habcd, 32'hffff_ffff}, {16'h0000, 32'h0000_0001},
                     {16'h0000, 32'h8000_0001}};
        default: ;
      endcase
      if (m != 0) load_map(words, m == 4);
      foreach (probes[p]) send_box(probes[p]);
      drain();
    end

    // Random part: a fresh map per phase; one long receiver hold-off, and the
    // last two phases and every third phase run with no idling at all.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idling_on = (phase % 3 != 2) && (phase < RANDOM_PHASES - 2);
      load_map(random_map(), $urandom_range(0, 2) == 0);
      if (phase == 1) hold_sink = 1'b1;
      for (int n = 0; n < BOXES_PER_PHASE; n++) send_box(random_box());
      drain();
    end

    if (bounds.mismatches == 0 && bounds.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
